>>> rtl/zone_wall_bracket_marker_defines.svh
// Assertion macros shared by the bracket marker modules.
// Each expects clk and arst_n in the scope where it is used.
`ifndef ZONE_WALL_BRACKET_MARKER_DEFINES_SVH
`define ZONE_WALL_BRACKET_MARKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZWBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/zwbm_pkg.sv
package zwbm_pkg;

	localparam int MAX_WORDS    = 64;
	localparam int WORD_ID_BITS = 16;

	localparam int ADDR_W   = $clog2(MAX_WORDS);
	localparam int CNT_W    = $clog2(MAX_WORDS + 1);
	localparam int ID_W     = WORD_ID_BITS;
	localparam int CLS_W    = 4;
	localparam int IN_ID_W  = 16;
	localparam int OUT_ID_W = 16;
	localparam int POS_W    = 6;
	localparam int ROLE_W   = 2;
	localparam int MARK_W   = 2;

	// token classes
	localparam logic [CLS_W-1:0] CLS_PLAIN   = 4'd0;
	localparam logic [CLS_W-1:0] CLS_COLON   = 4'd1;
	localparam logic [CLS_W-1:0] CLS_SEMI    = 4'd2;
	localparam logic [CLS_W-1:0] CLS_DASH    = 4'd3;
	localparam logic [CLS_W-1:0] CLS_QUOTE   = 4'd4;
	localparam logic [CLS_W-1:0] CLS_POPEN   = 4'd5;
	localparam logic [CLS_W-1:0] CLS_PCLOSE  = 4'd6;
	localparam logic [CLS_W-1:0] CLS_SOPEN   = 4'd7;
	localparam logic [CLS_W-1:0] CLS_SCLOSE  = 4'd8;

	// stored roles
	localparam logic [ROLE_W-1:0] ROLE_PLAIN = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_SEP   = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_OPEN  = 2'd2;
	localparam logic [ROLE_W-1:0] ROLE_CLOSE = 2'd3;

	// marker codes
	localparam logic [MARK_W-1:0] BEFORE_NONE = 2'd0;
	localparam logic [MARK_W-1:0] BEFORE_ZONE = 2'd1;
	localparam logic [MARK_W-1:0] BEFORE_WALL = 2'd2;
	localparam logic [MARK_W-1:0] AFTER_NONE  = 2'd0;
	localparam logic [MARK_W-1:0] AFTER_WALL  = 2'd1;
	localparam logic [MARK_W-1:0] AFTER_ZONE  = 2'd2;

	typedef struct packed {
		logic              word_we;
		logic [ADDR_W-1:0] word_addr;
		logic [ID_W-1:0]   word_data;
		logic              role_we;
		logic [ADDR_W-1:0] role_addr;
		logic [ROLE_W-1:0] role_data;
	} store_wr_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] addr;
	} store_rd_t;

	typedef struct packed {
		logic             start;
		logic [CNT_W-1:0] count;
		logic             ovf;
	} emit_cmd_t;

	function automatic logic [MARK_W-1:0] before_of(input logic [ROLE_W-1:0] role);
		logic [MARK_W-1:0] m;
		case (role)
			ROLE_SEP:   m = BEFORE_WALL;
			ROLE_OPEN:  m = BEFORE_ZONE;
			ROLE_CLOSE: m = BEFORE_WALL;
			default:    m = BEFORE_NONE;
		endcase
		return m;
	endfunction

	function automatic logic [MARK_W-1:0] after_of(input logic [ROLE_W-1:0] role);
		logic [MARK_W-1:0] m;
		case (role)
			ROLE_SEP:   m = AFTER_WALL;
			ROLE_OPEN:  m = AFTER_WALL;
			ROLE_CLOSE: m = AFTER_ZONE;
			default:    m = AFTER_NONE;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/zwbm_ram.sv
module zwbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while no read is issued
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/zwbm_load.sv
`include "zone_wall_bracket_marker_defines.svh"

module zwbm_load (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [zwbm_pkg::CLS_W-1:0]          token_class,
	input  logic [zwbm_pkg::IN_ID_W-1:0]        token_id,
	input  logic                                last,
	output zwbm_pkg::store_wr_t                 wr,
	output zwbm_pkg::emit_cmd_t                 cmd,
	input  logic                                done
);

	localparam int AW  = zwbm_pkg::ADDR_W;
	localparam int CW  = zwbm_pkg::CNT_W;
	localparam int IW  = zwbm_pkg::ID_W;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_FIX  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [1:0] FIX_QUOTE  = 2'd0;
	localparam logic [1:0] FIX_PAREN  = 2'd1;
	localparam logic [1:0] FIX_SQUARE = 2'd2;

	logic [1:0]    state_q;
	logic [1:0]    fsel_q;
	logic          last_q;
	logic          start_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pdepth_q;
	logic [CW-1:0] sdepth_q;
	logic          qpend_q;
	logic [AW-1:0] qpos_q;
	logic          ovf_q;

	logic                          accept;
	logic                          fits;
	logic                          ld;
	logic [AW-1:0]                 pos;
	logic                          p_push;
	logic                          p_pop;
	logic                          s_push;
	logic                          s_pop;
	logic                          q_match;
	logic                          need_fix;
	logic [CW-1:0]                 pdepth_dec;
	logic [CW-1:0]                 sdepth_dec;
	logic [AW-1:0]                 p_rdata;
	logic [AW-1:0]                 s_rdata;
	logic [AW-1:0]                 fix_addr;
	logic [zwbm_pkg::ROLE_W-1:0]   role_new;

	assign in_ready   = (state_q == ST_LOAD);
	assign accept     = in_valid && in_ready;
	assign fits       = (cnt_q < CW'(zwbm_pkg::MAX_WORDS));
	assign ld         = accept && fits;
	assign pos        = cnt_q[AW-1:0];
	assign pdepth_dec = pdepth_q - CW'(1);
	assign sdepth_dec = sdepth_q - CW'(1);

	assign p_push  = ld && (token_class == zwbm_pkg::CLS_POPEN);
	assign p_pop   = ld && (token_class == zwbm_pkg::CLS_PCLOSE) && (pdepth_q != '0);
	assign s_push  = ld && (token_class == zwbm_pkg::CLS_SOPEN);
	assign s_pop   = ld && (token_class == zwbm_pkg::CLS_SCLOSE) && (sdepth_q != '0);
	assign q_match = ld && (token_class == zwbm_pkg::CLS_QUOTE) && qpend_q;
	assign need_fix = p_pop || s_pop || q_match;

	always_comb begin
		role_new = zwbm_pkg::ROLE_PLAIN;
		if (token_class inside {zwbm_pkg::CLS_COLON, zwbm_pkg::CLS_SEMI,
				zwbm_pkg::CLS_DASH}) begin
			role_new = zwbm_pkg::ROLE_SEP;
		end else if (need_fix) begin
			role_new = zwbm_pkg::ROLE_CLOSE;
		end
	end

	always_comb begin
		case (fsel_q)
			FIX_PAREN:  fix_addr = p_rdata;
			FIX_SQUARE: fix_addr = s_rdata;
			default:    fix_addr = qpos_q;
		endcase
	end

	// role port: own role on load, partner's open role in the fix cycle
	always_comb begin
		wr.word_we   = ld;
		wr.word_addr = pos;
		wr.word_data = IW'(token_id);
		if (state_q == ST_FIX) begin
			wr.role_we   = 1'b1;
			wr.role_addr = fix_addr;
			wr.role_data = zwbm_pkg::ROLE_OPEN;
		end else begin
			wr.role_we   = ld;
			wr.role_addr = pos;
			wr.role_data = role_new;
		end
	end

	assign cmd.start = start_q;
	assign cmd.count = cnt_q;
	assign cmd.ovf   = ovf_q;

	zwbm_ram #(.WIDTH(AW), .DEPTH(zwbm_pkg::MAX_WORDS)) u_paren_stack (
		.clk   (clk),
		.we    (p_push),
		.waddr (pdepth_q[AW-1:0]),
		.wdata (pos),
		.re    (p_pop),
		.raddr (pdepth_dec[AW-1:0]),
		.rdata (p_rdata)
	);

	zwbm_ram #(.WIDTH(AW), .DEPTH(zwbm_pkg::MAX_WORDS)) u_square_stack (
		.clk   (clk),
		.we    (s_push),
		.waddr (sdepth_q[AW-1:0]),
		.wdata (pos),
		.re    (s_pop),
		.raddr (sdepth_dec[AW-1:0]),
		.rdata (s_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			fsel_q   <= FIX_QUOTE;
			last_q   <= 1'b0;
			start_q  <= 1'b0;
			cnt_q    <= '0;
			pdepth_q <= '0;
			sdepth_q <= '0;
			qpend_q  <= 1'b0;
			qpos_q   <= '0;
			ovf_q    <= 1'b0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						last_q <= last;
						if (fits) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (p_push) pdepth_q <= pdepth_q + CW'(1);
						if (p_pop)  pdepth_q <= pdepth_dec;
						if (s_push) sdepth_q <= sdepth_q + CW'(1);
						if (s_pop)  sdepth_q <= sdepth_dec;
						if (ld && (token_class == zwbm_pkg::CLS_QUOTE)) begin
							qpend_q <= !qpend_q;
							if (!qpend_q) qpos_q <= pos;
						end
						if (p_pop) begin
							fsel_q <= FIX_PAREN;
						end else if (s_pop) begin
							fsel_q <= FIX_SQUARE;
						end else begin
							fsel_q <= FIX_QUOTE;
						end
						if (need_fix) begin
							state_q <= ST_FIX;
						end else if (last) begin
							state_q <= ST_EMIT;
							start_q <= 1'b1;
						end
					end
				end
				ST_FIX: begin
					if (last_q) begin
						state_q <= ST_EMIT;
						start_q <= 1'b1;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					// drop the phrase once its last result has gone out
					if (done) begin
						state_q  <= ST_LOAD;
						cnt_q    <= '0;
						pdepth_q <= '0;
						sdepth_q <= '0;
						qpend_q  <= 1'b0;
						qpos_q   <= '0;
						ovf_q    <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`ZWBM_ASSERT_NEXT(a_fix_single, state_q == ST_FIX, state_q != ST_FIX, "fix phase lasted more than one cycle")
	`ZWBM_ASSERT_NOW(a_depth_bound, state_q == ST_LOAD, (pdepth_q <= cnt_q) && (sdepth_q <= cnt_q), "bracket depth exceeds stored tokens")

endmodule

>>> rtl/zwbm_emit.sv
`include "zone_wall_bracket_marker_defines.svh"

module zwbm_emit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  zwbm_pkg::emit_cmd_t                  cmd,
	output zwbm_pkg::store_rd_t                  rd,
	input  logic [zwbm_pkg::ID_W-1:0]            word_rdata,
	input  logic [zwbm_pkg::ROLE_W-1:0]          role_rdata,
	output logic                                 done,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [zwbm_pkg::POS_W-1:0]           position,
	output logic [zwbm_pkg::OUT_ID_W-1:0]        word_id,
	output logic [zwbm_pkg::MARK_W-1:0]          before_mark,
	output logic [zwbm_pkg::MARK_W-1:0]          after_mark,
	output logic                                 truncated,
	output logic                                 final_res
);

	localparam int AW = zwbm_pkg::ADDR_W;
	localparam int CW = zwbm_pkg::CNT_W;
	localparam int PW = zwbm_pkg::POS_W;
	localparam int OW = zwbm_pkg::OUT_ID_W;

	logic          active_q;
	logic [CW-1:0] n_q;
	logic          ovf_q;
	logic [CW-1:0] iss_q;
	logic          rd_valid_s1;
	logic [AW-1:0] rd_idx_s1;

	logic                          out_valid_q;
	logic [PW-1:0]                 pos_q;
	logic [OW-1:0]                 word_q;
	logic [zwbm_pkg::MARK_W-1:0]   bm_q;
	logic [zwbm_pkg::MARK_W-1:0]   am_q;
	logic                          trunc_q;
	logic                          fin_q;

	logic move;
	logic issue;

	// advance the read slot into the output register when it is free or drains
	assign move  = rd_valid_s1 && (!out_valid_q || out_ready);
	assign issue = active_q && (iss_q != n_q) && (!rd_valid_s1 || move);
	assign done  = out_valid_q && out_ready && fin_q;

	assign rd.re   = issue;
	assign rd.addr = iss_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			n_q         <= '0;
			ovf_q       <= 1'b0;
			iss_q       <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				active_q <= 1'b1;
				n_q      <= cmd.count;
				ovf_q    <= cmd.ovf;
				iss_q    <= '0;
			end else if (issue) begin
				iss_q <= iss_q + CW'(1);
			end
			if (done) begin
				active_q <= 1'b0;
			end
			if (issue) begin
				rd_valid_s1 <= 1'b1;
			end else if (move) begin
				rd_valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_idx_s1 <= iss_q[AW-1:0];
		end
		if (move) begin
			pos_q   <= PW'(rd_idx_s1);
			word_q  <= OW'(word_rdata);
			bm_q    <= zwbm_pkg::before_of(role_rdata);
			am_q    <= zwbm_pkg::after_of(role_rdata);
			trunc_q <= ovf_q;
			fin_q   <= ((CW'(rd_idx_s1) + CW'(1)) == n_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign position    = pos_q;
	assign word_id     = word_q;
	assign before_mark = bm_q;
	assign after_mark  = am_q;
	assign truncated   = trunc_q;
	assign final_res   = fin_q;

	`ZWBM_ASSERT_NOW(a_start_idle, cmd.start, !active_q && !out_valid_q && !rd_valid_s1, "emit started while a phrase is still going out")
	`ZWBM_ASSERT_NOW(a_final_pos, out_valid_q && fin_q, (CW'(pos_q) + CW'(1)) == n_q, "final result not at last stored position")

endmodule

>>> rtl/zone_wall_bracket_marker.sv
// Bracket and separator marker for one phrase. Tokens arrive already classed
// (plain, colon, semicolon, dash, quote, paren or square bracket) and are
// stored as they come, up to 64 per phrase; later ones are dropped and every
// result of that phrase then carries truncated. Quotes pair by toggling, and
// parens and square brackets pair through a stack per kind; a close with
// nothing open, an unclosed open and a lone quote stay plain. A close that
// finds its partner (a bracket or a second quote) is followed by a fix
// state before the next token is taken: the role memory has one write port,
// so the open's role is written in the cycle after the close. Once the
// token flagged last transfers and any fix state is through, the loader
// starts the emitter, the stores are read and the output register is
// loaded before out_valid rises for the first result. After that one
// result goes out per cycle while the receiver takes them, in order, with
// final_res on the last one. No new token is taken while a phrase is going
// out; the next phrase can start in the cycle after its final result
// transfers. The stores need no clearing pass after reset.
module zone_wall_bracket_marker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [zwbm_pkg::CLS_W-1:0]        token_class,
	input  logic [zwbm_pkg::IN_ID_W-1:0]      token_id,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [zwbm_pkg::POS_W-1:0]        position,
	output logic [zwbm_pkg::OUT_ID_W-1:0]     word_id,
	output logic [zwbm_pkg::MARK_W-1:0]       before_mark,
	output logic [zwbm_pkg::MARK_W-1:0]       after_mark,
	output logic                              truncated,
	output logic                              final_res
);

	zwbm_pkg::store_wr_t wr;
	zwbm_pkg::store_rd_t rd;
	zwbm_pkg::emit_cmd_t cmd;

	logic                        done;
	logic [zwbm_pkg::ID_W-1:0]   word_rdata;
	logic [zwbm_pkg::ROLE_W-1:0] role_rdata;

	// Loader: stores tokens, runs the pairing stacks, writes roles.
	zwbm_load u_load (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.token_class (token_class),
		.token_id    (token_id),
		.last        (last),
		.wr          (wr),
		.cmd         (cmd),
		.done        (done)
	);

	// Word identifiers, one entry per stored token.
	zwbm_ram #(.WIDTH(zwbm_pkg::ID_W), .DEPTH(zwbm_pkg::MAX_WORDS)) u_word_store (
		.clk   (clk),
		.we    (wr.word_we),
		.waddr (wr.word_addr),
		.wdata (wr.word_data),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (word_rdata)
	);

	// Token roles: plain, separator, matched open, matched close.
	zwbm_ram #(.WIDTH(zwbm_pkg::ROLE_W), .DEPTH(zwbm_pkg::MAX_WORDS)) u_role_store (
		.clk   (clk),
		.we    (wr.role_we),
		.waddr (wr.role_addr),
		.wdata (wr.role_data),
		.re    (rd.re),
		.raddr (rd.addr),
		.rdata (role_rdata)
	);

	// Emitter: walks the stores in order and drives the result channel.
	zwbm_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.rd          (rd),
		.word_rdata  (word_rdata),
		.role_rdata  (role_rdata),
		.done        (done),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.word_id     (word_id),
		.before_mark (before_mark),
		.after_mark  (after_mark),
		.truncated   (truncated),
		.final_res   (final_res)
	);

endmodule

>>> tb/tb_zone_wall_bracket_marker.sv
module tb_zone_wall_bracket_marker;
	timeunit 1ns;
	timeprecision 1ps;

	// Classes 9 to 15 carry no meaning and must load as plain tokens.
	localparam logic [zwbm_pkg::CLS_W-1:0] CLS_UNKNOWN_LO = 4'd9;
	localparam logic [zwbm_pkg::CLS_W-1:0] CLS_UNKNOWN_HI = 4'd15;

	localparam int RANDOM_TOKENS = 155;
	localparam int CALM_TOKENS   = 30;    // tail of the run with no idling on either side
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_MAX    = 10;

	// One marked word as it leaves the block.
	typedef struct packed {
		logic [zwbm_pkg::POS_W-1:0]    position;
		logic [zwbm_pkg::OUT_ID_W-1:0] word_id;
		logic [zwbm_pkg::MARK_W-1:0]   before_mark;
		logic [zwbm_pkg::MARK_W-1:0]   after_mark;
		logic                          truncated;
		logic                          final_res;
	} marked_word_t;

	// One row of the directed plan. Rows with known_marks set form a whole
	// one-token phrase whose result is typed in here.
	typedef struct {
		logic [zwbm_pkg::CLS_W-1:0]   cls;
		logic [zwbm_pkg::IN_ID_W-1:0] id;
		logic                         last;
		bit                           known_marks;
		logic [zwbm_pkg::MARK_W-1:0]  bm;
		logic [zwbm_pkg::MARK_W-1:0]  am;
	} token_row_t;

	logic                           clk;
	logic                           arst_n      = 1'b0;
	logic                           in_valid    = 1'b0;
	logic                           in_ready;
	logic [zwbm_pkg::CLS_W-1:0]     token_class = '0;
	logic [zwbm_pkg::IN_ID_W-1:0]   token_id    = '0;
	logic                           last        = 1'b0;
	logic                           out_valid;
	logic                           out_ready   = 1'b0;
	logic [zwbm_pkg::POS_W-1:0]     position;
	logic [zwbm_pkg::OUT_ID_W-1:0]  word_id;
	logic [zwbm_pkg::MARK_W-1:0]    before_mark;
	logic [zwbm_pkg::MARK_W-1:0]    after_mark;
	logic                           truncated;
	logic                           final_res;

	zone_wall_bracket_marker i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.token_class (token_class),
		.token_id    (token_id),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.position    (position),
		.word_id     (word_id),
		.before_mark (before_mark),
		.after_mark  (after_mark),
		.truncated   (truncated),
		.final_res   (final_res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Phrase state of the marker predictor.
	logic [zwbm_pkg::IN_ID_W-1:0] phrase_word [zwbm_pkg::MAX_WORDS];
	logic [zwbm_pkg::ROLE_W-1:0]  phrase_role [zwbm_pkg::MAX_WORDS];
	logic [zwbm_pkg::POS_W-1:0]   paren_open_at [zwbm_pkg::MAX_WORDS];
	logic [zwbm_pkg::POS_W-1:0]   square_open_at [zwbm_pkg::MAX_WORDS];
	int                           paren_level  = 0;
	int                           square_level = 0;
	bit                           quote_open   = 1'b0;
	logic [zwbm_pkg::POS_W-1:0]   quote_at     = '0;
	int                           words_held   = 0;
	bit                           words_lost   = 1'b0;

	marked_word_t marks_due[$];    // marked words still to come out, oldest first
	int           mismatches = 0;
	int           cycles     = 0;
	bit           calm       = 1'b0;

	function automatic string word_text(input marked_word_t w);
		return $sformatf("pos %0d id %h before %0d after %0d trunc %b final %b",
			w.position, w.word_id, w.before_mark, w.after_mark, w.truncated, w.final_res);
	endfunction

	// Load one accepted token into the predicted phrase; on the last token
	// queue the whole marked phrase and clear for the next one.
	task automatic mark_token(input logic [zwbm_pkg::CLS_W-1:0] cls,
			input logic [zwbm_pkg::IN_ID_W-1:0] id, input logic is_last);
		logic [zwbm_pkg::POS_W-1:0] pos;
		marked_word_t               mw;
		if (words_held < zwbm_pkg::MAX_WORDS) begin
			pos = zwbm_pkg::POS_W'(words_held);
			phrase_word[pos] = id;
			phrase_role[pos] = zwbm_pkg::ROLE_PLAIN;
			words_held++;
			case (cls)
				zwbm_pkg::CLS_COLON, zwbm_pkg::CLS_SEMI, zwbm_pkg::CLS_DASH:
					phrase_role[pos] = zwbm_pkg::ROLE_SEP;
				zwbm_pkg::CLS_QUOTE: begin
					// quotes pair by toggling: the second one closes the first
					if (quote_open) begin
						phrase_role[quote_at] = zwbm_pkg::ROLE_OPEN;
						phrase_role[pos] = zwbm_pkg::ROLE_CLOSE;
						quote_open = 1'b0;
					end else begin
						quote_open = 1'b1;
						quote_at = pos;
					end
				end
				zwbm_pkg::CLS_POPEN: begin
					paren_open_at[paren_level] = pos;
					paren_level++;
				end
				zwbm_pkg::CLS_PCLOSE: begin
					if (paren_level > 0) begin
						paren_level--;
						phrase_role[paren_open_at[paren_level]] = zwbm_pkg::ROLE_OPEN;
						phrase_role[pos] = zwbm_pkg::ROLE_CLOSE;
					end
				end
				zwbm_pkg::CLS_SOPEN: begin
					square_open_at[square_level] = pos;
					square_level++;
				end
				zwbm_pkg::CLS_SCLOSE: begin
					if (square_level > 0) begin
						square_level--;
						phrase_role[square_open_at[square_level]] = zwbm_pkg::ROLE_OPEN;
						phrase_role[pos] = zwbm_pkg::ROLE_CLOSE;
					end
				end
				default: ;
			endcase
		end else begin
			words_lost = 1'b1;
		end
		if (is_last) begin
			for (int i = 0; i < words_held; i++) begin
				mw.position  = zwbm_pkg::POS_W'(i);
				mw.word_id   = phrase_word[i];
				mw.truncated = words_lost;
				mw.final_res = (i == words_held - 1);
				case (phrase_role[i])
					zwbm_pkg::ROLE_SEP: begin
						mw.before_mark = zwbm_pkg::BEFORE_WALL;
						mw.after_mark  = zwbm_pkg::AFTER_WALL;
					end
					zwbm_pkg::ROLE_OPEN: begin
						mw.before_mark = zwbm_pkg::BEFORE_ZONE;
						mw.after_mark  = zwbm_pkg::AFTER_WALL;
					end
					zwbm_pkg::ROLE_CLOSE: begin
						mw.before_mark = zwbm_pkg::BEFORE_WALL;
						mw.after_mark  = zwbm_pkg::AFTER_ZONE;
					end
					default: begin
						mw.before_mark = zwbm_pkg::BEFORE_NONE;
						mw.after_mark  = zwbm_pkg::AFTER_NONE;
					end
				endcase
				marks_due.insert(marks_due.size(), mw);
			end
			paren_level  = 0;
			square_level = 0;
			quote_open   = 1'b0;
			quote_at     = '0;
			words_held   = 0;
			words_lost   = 1'b0;
		end
	endtask

	// Present one token and hold it until the transfer. Idle for a random
	// burst first, now and then, outside the calm tail.
	task automatic send_token(input token_row_t row);
		marked_word_t typed;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		token_class <= row.cls;
		token_id    <= row.id;
		last        <= row.last;
		do @(posedge clk); while (!in_ready);
		mark_token(row.cls, row.id, row.last);
		if (row.known_marks) begin
			// swap the predicted word for the one read straight off the rules
			typed = '{position: '0, word_id: row.id, before_mark: row.bm,
				after_mark: row.am, truncated: 1'b0, final_res: 1'b1};
			marks_due[marks_due.size() - 1] = typed;
		end
	endtask

	function automatic logic [zwbm_pkg::CLS_W-1:0] CLS_CLASS_SEP();
		case ($urandom_range(0, 2))
			0: return zwbm_pkg::CLS_COLON;
			1: return zwbm_pkg::CLS_SEMI;
			default: return zwbm_pkg::CLS_DASH;
		endcase
	endfunction

	// Build one phrase of len tokens. Most phrases close each bracket in proper
	// nesting and toggle quotes freely, with random fill; noisy ones take any class.
	task automatic send_phrase(input int len, input bit noisy);
		token_row_t                 row;
		logic [zwbm_pkg::CLS_W-1:0] open_kinds[$];
		bit                         in_quote;
		int                         pick;
		in_quote = 1'b0;
		for (int k = 0; k < len; k++) begin
			pick = noisy ? 9 : $urandom_range(0, 9);
			case (pick)
				0, 1, 2: row.cls = zwbm_pkg::CLS_PLAIN;
				3: row.cls = CLS_CLASS_SEP();
				4: row.cls = zwbm_pkg::CLS_POPEN;
				5: row.cls = zwbm_pkg::CLS_SOPEN;
				6: begin
					row.cls = zwbm_pkg::CLS_QUOTE;
					in_quote = !in_quote;
				end
				7, 8: begin
					if (open_kinds.size() != 0)
						row.cls = (open_kinds.pop_back() == zwbm_pkg::CLS_POPEN) ?
							zwbm_pkg::CLS_PCLOSE : zwbm_pkg::CLS_SCLOSE;
					else
						row.cls = zwbm_pkg::CLS_PLAIN;
				end
				default: row.cls = zwbm_pkg::CLS_W'($urandom_range(0, 15));
			endcase
			if (!noisy && (row.cls == zwbm_pkg::CLS_POPEN || row.cls == zwbm_pkg::CLS_SOPEN))
				open_kinds.insert(open_kinds.size(), row.cls);
			case ($urandom_range(0, 7))
				0: row.id = '0;
				1: row.id = '1;
				default: row.id = zwbm_pkg::IN_ID_W'($urandom);
			endcase
			row.last        = (k == len - 1);
			row.known_marks = 1'b0;
			send_token(row);
		end
	endtask

	// Directed plan: one-token phrases covering every class but the square open, the id extremes
	// and the lone cases, then phrases with nested, crossed and broken pairs.
	token_row_t plan [25] = '{
		'{zwbm_pkg::CLS_PLAIN,  16'h0000, 1'b1, 1'b1, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_COLON,  16'hFFFF, 1'b1, 1'b1, zwbm_pkg::BEFORE_WALL, zwbm_pkg::AFTER_WALL},
		'{zwbm_pkg::CLS_SEMI,   16'h8001, 1'b1, 1'b1, zwbm_pkg::BEFORE_WALL, zwbm_pkg::AFTER_WALL},
		'{zwbm_pkg::CLS_DASH,   16'h7FFE, 1'b1, 1'b1, zwbm_pkg::BEFORE_WALL, zwbm_pkg::AFTER_WALL},
		'{zwbm_pkg::CLS_QUOTE,  16'h1234, 1'b1, 1'b1, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_POPEN,  16'h0001, 1'b1, 1'b1, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_PCLOSE, 16'h0002, 1'b1, 1'b1, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_SCLOSE, 16'h0003, 1'b1, 1'b1, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{CLS_UNKNOWN_HI,       16'hABCD, 1'b1, 1'b1, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{CLS_UNKNOWN_LO,       16'h5555, 1'b1, 1'b1, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		// ( [ " x " ] : )
		'{zwbm_pkg::CLS_POPEN,  16'h0010, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_SOPEN,  16'h0011, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_QUOTE,  16'h0012, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_PLAIN,  16'h0013, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_QUOTE,  16'h0014, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_SCLOSE, 16'h0015, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_COLON,  16'h0016, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_PCLOSE, 16'h0017, 1'b1, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		// [ ( ] ) : each kind pairs on its own stack
		'{zwbm_pkg::CLS_SOPEN,  16'h0020, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_POPEN,  16'h0021, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_SCLOSE, 16'h0022, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_PCLOSE, 16'h0023, 1'b1, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		// ) [ " : stray close, then an open and a quote left hanging
		'{zwbm_pkg::CLS_PCLOSE, 16'h0030, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_SOPEN,  16'h0031, 1'b0, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE},
		'{zwbm_pkg::CLS_QUOTE,  16'h0032, 1'b1, 1'b0, zwbm_pkg::BEFORE_NONE, zwbm_pkg::AFTER_NONE}
	};

	// Output side: take a transfer only when valid and ready were both high
	// before the edge, and check it against the oldest predicted word.
	always @(posedge clk) begin
		marked_word_t got;
		marked_word_t want;
		if (arst_n && out_valid && out_ready) begin
			got = '{position, word_id, before_mark, after_mark, truncated, final_res};
			if (marks_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected word: %s", word_text(got));
			end else begin
				want = marks_due.pop_front();
				if (got.position !== want.position || got.word_id !== want.word_id ||
						got.before_mark !== want.before_mark ||
						got.after_mark !== want.after_mark ||
						got.truncated !== want.truncated || got.final_res !== want.final_res) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: expected %s, got %s",
							word_text(want), word_text(got));
				end
			end
		end
	end

	// Receiver stalls in random bursts, with open stretches between them.
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Watchdog: end a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int sent;
		bit overflow_done;
		sent = 0;
		overflow_done = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r])
			send_token(plan[r]);

		// Hold the sender until every word of the directed part is out.
		in_valid <= 1'b0;
		while (marks_due.size() != 0)
			@(posedge clk);

		while (sent < RANDOM_TOKENS) begin
			int len;
			calm = (sent >= RANDOM_TOKENS - CALM_TOKENS);
			if (!overflow_done && sent >= 40) begin
				// past capacity: the last token itself is dropped, the phrase still goes out
				len = zwbm_pkg::MAX_WORDS + $urandom_range(1, 3);
				send_phrase(len, 1'b0);
				overflow_done = 1'b1;
			end else begin
				len = $urandom_range(1, 10);
				send_phrase(len, $urandom_range(0, 3) == 0);
			end
			sent += len;
		end

		in_valid <= 1'b0;
		while (marks_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && marks_due.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
